// ----- rtl/core/pida_pkg.sv -----
// shared types and constants for the positional insert/delete array
`default_nettype none

package pida_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 64;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned INDEX_W          = 7;
  localparam int unsigned LEN_OUT_W        = 7;
  localparam int unsigned CMD_W            = 3;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned IN_TDATA_W       = 40;
  localparam int unsigned OUT_TDATA_W      = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_FILL   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // operation broadcast to every cell, already checked for range
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_INSERT,
    OP_REMOVE,
    OP_FILL
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/pida_cell.sv -----
// one entry cell of the array, shifting from either neighbour
`default_nettype none

module pida_cell #(
  parameter int unsigned POS   = 0,
  parameter int unsigned CMP_W = 7
) (
  input  wire logic                          clk_i,
  input  wire pida_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [CMP_W-1:0]              len_i,
  input  wire logic [pida_pkg::DATA_W-1:0]   left_i,
  input  wire logic [pida_pkg::DATA_W-1:0]   right_i,
  output logic      [pida_pkg::DATA_W-1:0]   data_o,
  output logic      [pida_pkg::DATA_W-1:0]   rd_o
);

  localparam logic [CMP_W-1:0] PosV     = CMP_W'(POS);
  localparam logic [CMP_W-1:0] PosNextV = CMP_W'(POS + 1);

  logic [pida_pkg::DATA_W-1:0] data_d, data_q;
  logic [CMP_W-1:0]            idx;

  assign idx = CMP_W'(ctrl_i.index);

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      pida_pkg::OP_SET: begin
        if (PosV == idx) data_d = ctrl_i.value;
      end
      pida_pkg::OP_INSERT: begin
        if (PosV == idx) begin
          data_d = ctrl_i.value;
        end else if (PosV > idx && PosV <= len_i) begin
          data_d = left_i;
        end
      end
      pida_pkg::OP_REMOVE: begin
        if (PosV >= idx && PosNextV < len_i) data_d = right_i;
      end
      pida_pkg::OP_FILL: begin
        if (PosV < len_i) data_d = ctrl_i.value;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (PosV == idx) ? data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/pida_row.sv -----
// row of entry cells with the read-out merge
`default_nettype none

module pida_row #(
  parameter int unsigned CAPACITY = pida_pkg::DEFAULT_CAPACITY,
  parameter int unsigned CMP_W    = 7
) (
  input  wire logic                          clk_i,
  input  wire pida_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [CMP_W-1:0]              len_i,
  output logic      [pida_pkg::DATA_W-1:0]   rd_o
);

  logic [CAPACITY-1:0][pida_pkg::DATA_W-1:0] data;
  logic [CAPACITY-1:0][pida_pkg::DATA_W-1:0] cell_rd;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pida_pkg::DATA_W-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    pida_cell #(
      .POS   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .len_i   (len_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // only the addressed cell drives a non-zero word
  always_comb begin
    rd_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_o = rd_o | cell_rd[i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/positional_insert_delete_array.sv -----
// top level of the positional insert/delete array
//
//  channel   direction  tdata                              tuser
//  s_axis    in         index[6:0] value[38:7]             command[2:0]
//  m_axis    out        read_value[31:0] length[38:32]     status[1:0]
//  cfg       in         start_length[6:0]                  -
//
//  one command per cycle while results are taken: every cell updates in the
//  accepting cycle, the result register holds the answer from the next cycle on
//  the get path is the merge of all cell read-outs into one word
//  a new command is taken while the result waits, as long as that result
//  is taken in the same cycle
//  reset clears the length and the result valid, entries hold no reset
`default_nettype none

module positional_insert_delete_array #(
  parameter int unsigned CAPACITY = pida_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // index, value
  input  wire logic [pida_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // command
  input  wire logic [pida_pkg::CMD_W-1:0]          s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // read_value, length
  output logic      [pida_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // status
  output logic      [pida_pkg::STATUS_W-1:0]       m_axis_tuser_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pida_pkg::LEN_OUT_W-1:0]      cfg_data_i
);

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (LEN_W > pida_pkg::INDEX_W) ? LEN_W : pida_pkg::INDEX_W;
  localparam logic [CMP_W-1:0] CapV = CMP_W'(CAPACITY);

  logic [LEN_W-1:0]                  len_d, len_q;
  logic                              out_valid_d, out_valid_q;
  logic [pida_pkg::DATA_W-1:0]       out_rd_d, out_rd_q;
  pida_pkg::status_e                 out_st_d, out_st_q;
  logic [pida_pkg::LEN_OUT_W-1:0]    out_len_q;

  logic                              s_fire, cfg_fire;
  pida_pkg::cmd_e                    cmd;
  logic [pida_pkg::INDEX_W-1:0]      in_index;
  logic [pida_pkg::DATA_W-1:0]       in_value;
  logic [CMP_W-1:0]                  idx_ext, len_ext, cfg_ext;
  logic [LEN_W-1:0]                  len_cmd;
  pida_pkg::cell_ctrl_t              ctrl;
  logic [pida_pkg::DATA_W-1:0]       row_rd;

  assign cmd      = pida_pkg::cmd_e'(s_axis_tuser_i);
  assign in_index = s_axis_tdata_i[pida_pkg::INDEX_W-1:0];
  assign in_value = s_axis_tdata_i[pida_pkg::INDEX_W +: pida_pkg::DATA_W];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_fire        = cfg_valid_i && cfg_ready_o;

  assign idx_ext = CMP_W'(in_index);
  assign len_ext = CMP_W'(len_q);
  assign cfg_ext = CMP_W'(cfg_data_i);

  // command decode and range checks
  always_comb begin
    ctrl.op    = pida_pkg::OP_NONE;
    ctrl.index = in_index;
    ctrl.value = in_value;
    len_cmd    = len_q;
    out_rd_d   = '0;
    out_st_d   = pida_pkg::ST_OK;
    unique case (cmd)
      pida_pkg::CMD_GET: begin
        if (idx_ext < len_ext) begin
          out_rd_d = row_rd;
        end else begin
          out_rd_d = '1;
          out_st_d = pida_pkg::ST_RANGE;
        end
      end
      pida_pkg::CMD_SET: begin
        if (idx_ext < len_ext) ctrl.op = pida_pkg::OP_SET;
        else out_st_d = pida_pkg::ST_RANGE;
      end
      pida_pkg::CMD_INSERT: begin
        priority if (idx_ext > len_ext) begin
          out_st_d = pida_pkg::ST_RANGE;
        end else if (len_ext >= CapV) begin
          out_st_d = pida_pkg::ST_FULL;
        end else begin
          ctrl.op = pida_pkg::OP_INSERT;
          len_cmd = len_q + 1'b1;
        end
      end
      pida_pkg::CMD_REMOVE: begin
        if (idx_ext < len_ext) begin
          ctrl.op = pida_pkg::OP_REMOVE;
          len_cmd = len_q - 1'b1;
        end else begin
          out_st_d = pida_pkg::ST_RANGE;
        end
      end
      pida_pkg::CMD_FILL: ctrl.op = pida_pkg::OP_FILL;
      default: ctrl.op = pida_pkg::OP_NONE;
    endcase
    if (!s_fire) ctrl.op = pida_pkg::OP_NONE;
  end

  always_comb begin
    len_d = len_q;
    if (cfg_fire) begin
      len_d = (cfg_ext > CapV) ? LEN_W'(CAPACITY) : LEN_W'(cfg_ext);
    end else if (s_fire) begin
      len_d = len_cmd;
    end
    out_valid_d = s_fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_rd_q  <= out_rd_d;
      out_st_q  <= out_st_d;
      out_len_q <= pida_pkg::LEN_OUT_W'(len_cmd);
    end
  end

  pida_row #(
    .CAPACITY (CAPACITY),
    .CMP_W    (CMP_W)
  ) u_row (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .len_i  (len_ext),
    .rd_o   (row_rd)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_len_q, out_rd_q};
  assign m_axis_tuser_o  = out_st_q;

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(len_q) <= CapV)
    else $error("length above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !cfg_fire && cmd == pida_pkg::CMD_INSERT && out_st_d == pida_pkg::ST_OK
    |=> len_q == LEN_W'($past(len_q) + 1'b1))
    else $error("insert did not grow length");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !cfg_fire && cmd == pida_pkg::CMD_REMOVE && out_st_d == pida_pkg::ST_OK
    |=> len_q == LEN_W'($past(len_q) - 1'b1))
    else $error("remove did not shrink length");

  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && out_st_d == pida_pkg::ST_FULL |-> CMP_W'(len_q) == CapV)
    else $error("full status below capacity");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> out_valid_q)
    else $error("transfer without result");

endmodule

`default_nettype wire

// ----- test/tb_positional_insert_delete_array.sv -----
// self-checking testbench for the positional insert/delete array
module tb_positional_insert_delete_array;
  import pida_pkg::*;

  localparam int unsigned CAPACITY = DEFAULT_CAPACITY;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;

  typedef struct {
    logic [DATA_W-1:0] read_value;
    status_e status;
    logic [LEN_OUT_W-1:0] length;
  } answer_t;

  // mirror of the table: words, which slots hold a written word, the length
  class answer_book;
    logic [DATA_W-1:0] words [CAPACITY];
    bit stored [CAPACITY];
    int unsigned len;
    answer_t due [$];
    int unsigned errors;

    function new();
      len = 0;
      errors = 0;
      foreach (stored[i]) stored[i] = 1'b0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void load_length(logic [LEN_OUT_W-1:0] v);
      len = (v > CAPACITY) ? CAPACITY : v;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                               logic [DATA_W-1:0] val);
      answer_t a;
      int i;
      a.read_value = '0;
      a.status = ST_OK;
      case (cmd)
        CMD_GET: begin
          if (idx < len) a.read_value = words[idx];
          else begin
            a.read_value = '1;
            a.status = ST_RANGE;
          end
        end
        CMD_SET: begin
          if (idx < len) begin
            words[idx] = val;
            stored[idx] = 1'b1;
          end else a.status = ST_RANGE;
        end
        CMD_INSERT: begin
          if (idx > len) a.status = ST_RANGE;
          else if (len >= CAPACITY) a.status = ST_FULL;
          else begin
            for (i = len; i > idx; i--) begin
              words[i] = words[i-1];
              stored[i] = stored[i-1];
            end
            words[idx] = val;
            stored[idx] = 1'b1;
            len++;
          end
        end
        CMD_REMOVE: begin
          if (idx >= len) a.status = ST_RANGE;
          else begin
            for (i = idx; i + 1 < len; i++) begin
              words[i] = words[i+1];
              stored[i] = stored[i+1];
            end
            len--;
          end
        end
        CMD_FILL: begin
          for (i = 0; i < len; i++) begin
            words[i] = val;
            stored[i] = 1'b1;
          end
        end
        default: ;
      endcase
      a.length = LEN_OUT_W'(len);
      due.push_back(a);
    endfunction

    function void check_answer(logic [DATA_W-1:0] rd, logic [STATUS_W-1:0] st,
                               logic [LEN_OUT_W-1:0] ln);
      answer_t a;
      if (due.size() == 0) begin
        $error("result transfer with nothing due: read_value %0d status %0d length %0d",
               $signed(rd), st, ln);
        errors++;
      end else begin
        a = due.pop_front();
        if (rd !== a.read_value) begin
          $error("read_value: expected %0d, got %0d", $signed(a.read_value), $signed(rd));
          errors++;
        end
        if (st !== a.status) begin
          $error("status: expected %0d, got %0d", a.status, st);
          errors++;
        end
        if (ln !== a.length) begin
          $error("length: expected %0d, got %0d", a.length, ln);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [LEN_OUT_W-1:0] cfg_data = '0;

  wire s_axis_tready_o;
  wire m_axis_tvalid_o;
  wire [OUT_TDATA_W-1:0] m_axis_tdata_o;
  wire [STATUS_W-1:0] m_axis_tuser_o;
  wire cfg_ready_o;

  answer_book sb = new();

  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  logic [1:0] rx_mode = 2'd0;
  logic [5:0] rx_clock = '0;
  int unsigned cycle_count = 0;

  positional_insert_delete_array #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    // index[6:0], value[38:7]
    .s_axis_tdata_i(s_tdata),
    // command[2:0]
    .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    // read_value[31:0], length[38:32]
    .m_axis_tdata_o(m_axis_tdata_o),
    // status[1:0]
    .m_axis_tuser_o(m_axis_tuser_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("positional_insert_delete_array: mismatch");
      $finish;
    end
  end

  // receiver: long hold-offs on request, otherwise a changing stall pattern
  always @(posedge clk_i) begin
    if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      rx_clock <= rx_clock + 1'b1;
      if (rx_clock == '0) rx_mode <= 2'($urandom_range(3, 0));
      case (rx_mode)
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(1, 0));
        2'd2: m_tready <= (rx_clock[1:0] == 2'd0);
        default: m_tready <= rx_clock[0];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_answer(m_axis_tdata_o[DATA_W-1:0],
                      m_axis_tuser_o,
                      m_axis_tdata_o[DATA_W +: LEN_OUT_W]);
  end

  task automatic offer(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                       logic [DATA_W-1:0] val);
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W - DATA_W - INDEX_W){1'b0}}, val, idx};
    s_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(cmd, idx, val);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.due.size() != 0);
  endtask

  task automatic write_start_length(logic [LEN_OUT_W-1:0] v);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.load_length(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_command(input int unsigned ins_pct, output logic [CMD_W-1:0] cmd,
                              output logic [INDEX_W-1:0] idx,
                              output logic [DATA_W-1:0] val);
    int unsigned r;
    int unsigned top;
    r = $urandom_range(99, 0);
    if (r < 3) cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    else if (r < 18) cmd = CMD_GET;
    else if (r < 33) cmd = CMD_SET;
    else if (r < 38) cmd = CMD_FILL;
    else if ($urandom_range(99, 0) < ins_pct) cmd = CMD_INSERT;
    else cmd = CMD_REMOVE;
    top = (sb.len > 0) ? sb.len - 1 : 0;
    case ($urandom_range(9, 0))
      0: idx = INDEX_W'($urandom_range(127, 0));
      1: idx = INDEX_W'(sb.len);
      2: idx = '0;
      default: idx = INDEX_W'($urandom_range(top, 0));
    endcase
    // a word that was never stored must not be read back
    if (cmd == CMD_GET && idx < sb.len && !sb.stored[idx]) cmd = CMD_SET;
    case ($urandom_range(15, 0))
      0: val = '0;
      1: val = '1;
      2: val = 32'h7fff_ffff;
      3: val = 32'h8000_0000;
      default: val = $urandom;
    endcase
  endtask

  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned burst;
    int unsigned ins_pct;
    int unsigned phase_len [PHASES];
    logic [CMD_W-1:0] c;
    logic [INDEX_W-1:0] ix;
    logic [DATA_W-1:0] v;

    phase_len = '{0, 64, 127, 1, 63, 100, 0, 0};
    phase_len[6] = $urandom_range(62, 2);
    phase_len[7] = $urandom_range(127, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, range checks, then a few words
    write_start_length('0);
    offer(CMD_FILL, 7'd0, 32'd5);
    offer(CMD_GET, 7'd0, '0);
    offer(CMD_SET, 7'd0, 32'd9);
    offer(CMD_REMOVE, 7'd0, '0);
    offer(CMD_INSERT, 7'd1, 32'd3);
    offer(CMD_INSERT, 7'd127, '1);
    offer(CMD_INSERT, 7'd0, 32'h7fff_ffff);
    offer(CMD_INSERT, 7'd0, 32'h8000_0000);
    offer(CMD_INSERT, 7'd2, '1);
    offer(CMD_GET, 7'd0, '0);
    offer(CMD_GET, 7'd2, '0);
    offer(CMD_GET, 7'd3, '0);
    offer(CMD_SET, 7'd1, '0);
    offer(CMD_REMOVE, 7'd1, '0);
    offer(CMD_REMOVE, 7'd2, '0);
    for (c = CMD_SPARE_FIRST; c != CMD_SPARE_LAST; c++) offer(c, 7'd127, '1);
    offer(CMD_SPARE_LAST, 7'd127, '1);
    offer(CMD_FILL, 7'd0, 32'ha5a5_a5a5);
    offer(CMD_GET, 7'd1, '0);

    // full table: range check wins over the full check
    write_start_length(7'd64);
    offer(CMD_INSERT, 7'd0, 32'd1);
    offer(CMD_INSERT, 7'd65, 32'd1);
    offer(CMD_FILL, 7'd0, '0);
    offer(CMD_REMOVE, 7'd63, '0);
    offer(CMD_INSERT, 7'd63, 32'd1);
    offer(CMD_GET, 7'd63, '0);

    // saturating start length
    write_start_length(7'd127);
    offer(CMD_INSERT, 7'd64, 32'd2);

    for (p = 0; p < PHASES; p++) begin
      write_start_length(LEN_OUT_W'(phase_len[p]));
      ins_pct = $urandom_range(75, 35);
      burst = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk_i);
          burst = $urandom_range(40, 1);
        end
        pick_command(ins_pct, c, ix, v);
        offer(c, ix, v);
        burst--;
        if ((p == 1 && n == 100) || (p == 4 && n == 60)) holds_asked <= holds_asked + 1;
        if (p == 3 && n == 120) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("positional_insert_delete_array: match");
    end else begin
      $display("positional_insert_delete_array: mismatch");
    end
    $finish;
  end
endmodule
